// ===== rtl/efp_pkg.sv =====
// ----------------------------------------------------------------------------
// efp_pkg: shared types and helpers for the escape-time fractal pixel engine
// Fixed-point types, register indexes, sequencer states, 32-bit saturation.
// ----------------------------------------------------------------------------
package efp_pkg;

  // Signed Q8.24 coordinate and its full-width product.
  typedef logic signed [31:0] q824_t;
  typedef logic signed [63:0] prod_t;

  // One 8-bit color channel.
  typedef logic [7:0] chan_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_STEP_X   = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_STEP_Y   = 3'd3,
    REG_JULIA_RE = 3'd4,
    REG_JULIA_IM = 3'd5,
    REG_ESC_LIM  = 3'd6,
    REG_MODE     = 3'd7
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MX,
    S_MY,
    S_MZ,
    S_XX,
    S_YY,
    S_XY,
    S_UPD,
    S_DONE
  } state_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic q824_t sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/efp_mul.sv =====
// ----------------------------------------------------------------------------
// efp_mul: shared signed multiplier
// One 32x32 signed multiply per cycle, product registered.
// ----------------------------------------------------------------------------
module efp_mul (
  input  logic           clk,
  input  efp_pkg::q824_t op_a,
  input  efp_pkg::q824_t op_b,
  output efp_pkg::prod_t prod_r
);
  import efp_pkg::*;

  prod_t prod_nxt;

  // Full-precision product of the two sign-extended 32-bit operands.
  assign prod_nxt = 64'(op_a) * 64'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/efp_ramp.sv =====
// ----------------------------------------------------------------------------
// efp_ramp: incremental color ramp channel
// Tracks floor(i * SCALE / LIMIT) mod 256 as i steps up by one, using a
// quotient and a running remainder, so no divider is needed.
// ----------------------------------------------------------------------------
module efp_ramp #(
  parameter int SCALE = 255,
  parameter int LIMIT = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          step,
  output efp_pkg::chan_t level_r
);
  import efp_pkg::*;

  localparam int QUO = SCALE / LIMIT;
  localparam int REM = SCALE % LIMIT;
  localparam int RW  = $clog2(LIMIT) + 1;

  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW:0]   rem_sum;
  chan_t         level_nxt;

  // Add the fixed remainder and carry into the quotient when it wraps.
  always_comb begin
    rem_sum   = {1'b0, rem_r} + (RW+1)'(REM);
    rem_nxt   = rem_r;
    level_nxt = level_r;
    if (clear) begin
      rem_nxt   = '0;
      level_nxt = '0;
    end else if (step) begin
      if (rem_sum >= (RW+1)'(LIMIT)) begin
        rem_nxt   = RW'(rem_sum - (RW+1)'(LIMIT));
        level_nxt = level_r + 8'(QUO) + 8'd1;
      end else begin
        rem_nxt   = RW'(rem_sum);
        level_nxt = level_r + 8'(QUO);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      level_r <= '0;
    end else begin
      rem_r   <= rem_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

// ===== rtl/escape_time_fractal_pixel_top.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_top: Mandelbrot / Julia escape-time pixel engine
// Maps one pixel to a complex point and iterates z = z*z + c in Q8.24.
// ----------------------------------------------------------------------------
// One pixel request is worked at a time. All multiplications go through a
// single shared 32x32 multiplier: mapping the pixel multiplies the column and
// row by their steps, and each iteration of z = z*z + c runs the steps zx*zx,
// zy*zy, zx*zy and update. The escape test of an index reuses the squares of
// that iteration. The done state waits until the output register is free; the
// sequencer then loads the result into it and returns to idle, where the next
// request is accepted even while that result still waits to be taken.
module escape_time_fractal_pixel_top #(
  parameter int ITER_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Pixel request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_pixel_x,
  input  logic [9:0]  in_pixel_y,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_x,
  output logic [9:0]  out_y,
  output logic [23:0] out_pixel_color,
  output logic [8:0]  out_iterations,
  output logic        out_escaped
);
  import efp_pkg::*;

  localparam int CNT_W = $clog2(ITER_LIMIT + 1);

  // Configuration registers.
  q824_t       origin_x_r, step_x_r, origin_y_r, step_y_r;
  q824_t       julia_re_r, julia_im_r;
  logic [30:0] esc_lim_r;
  logic [1:0]  mode_r;

  // Sequencer and datapath state.
  state_t           state_r, state_nxt;
  logic [9:0]       px_r, px_nxt, py_r, py_nxt;
  q824_t            zx_r, zx_nxt, zy_r, zy_nxt;
  q824_t            cx_r, cx_nxt, cy_r, cy_nxt;
  prod_t            xx_r, xx_nxt, yy_r, yy_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             esc_r, esc_nxt;
  logic [8:0]       iter_r, iter_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [23:0] out_color_r, out_color_nxt;
  logic [8:0]  out_iter_r, out_iter_nxt;
  logic        out_esc_r, out_esc_nxt;

  // Shared multiplier and ramp channels.
  q824_t mul_a, mul_b;
  prod_t prod_r;
  logic  ramp_clear, ramp_step;
  chan_t red_r, green_r, blue_r;

  // Datapath helpers.
  logic               accept;
  logic               out_free;
  logic [63:0]        mag;
  logic [54:0]        lim_wide;
  logic               escape_hit;
  logic               last_iter;
  logic signed [63:0] diff;
  logic signed [47:0] map_x_sum, map_y_sum, upd_re_sum, upd_im_sum;

  efp_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  efp_ramp #(.SCALE(255), .LIMIT(ITER_LIMIT)) u_ramp_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (ramp_clear),
    .step    (ramp_step),
    .level_r (red_r)
  );

  efp_ramp #(.SCALE(128), .LIMIT(ITER_LIMIT)) u_ramp_green (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (ramp_clear),
    .step    (ramp_step),
    .level_r (green_r)
  );

  efp_ramp #(.SCALE(64), .LIMIT(ITER_LIMIT)) u_ramp_blue (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (ramp_clear),
    .step    (ramp_step),
    .level_r (blue_r)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= -32'sd33554432;
      step_x_r   <= 32'sd65536;
      origin_y_r <= 32'sd33554432;
      step_y_r   <= -32'sd65536;
      julia_re_r <= '0;
      julia_im_r <= '0;
      esc_lim_r  <= 31'd67108864;
      mode_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: origin_x_r <= cfg_data;
        REG_STEP_X:   step_x_r   <= cfg_data;
        REG_ORIGIN_Y: origin_y_r <= cfg_data;
        REG_STEP_Y:   step_y_r   <= cfg_data;
        REG_JULIA_RE: julia_re_r <= cfg_data;
        REG_JULIA_IM: julia_im_r <= cfg_data;
        REG_ESC_LIM:  esc_lim_r  <= cfg_data[30:0];
        REG_MODE:     mode_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Handshake and escape test terms.
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign mag        = 64'(xx_r) + 64'(prod_r);
  assign lim_wide   = {esc_lim_r, 24'd0};
  assign escape_hit = !first_r && (mag > 64'(lim_wide));
  assign last_iter  = (cnt_r == CNT_W'(ITER_LIMIT - 1));

  // Pixel mapping and iteration sums; the shifts are floor divisions.
  assign map_x_sum  = {{16{origin_x_r[31]}}, origin_x_r} + prod_r[47:0];
  assign map_y_sum  = {{16{origin_y_r[31]}}, origin_y_r} + prod_r[47:0];
  assign diff       = xx_r - yy_r;
  assign upd_re_sum = {{8{diff[63]}}, diff[63:24]} + {{16{cx_r[31]}}, cx_r};
  assign upd_im_sum = {{7{prod_r[63]}}, prod_r[63:23]} + {{16{cy_r[31]}}, cy_r};

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_MZ;
      S_MZ:   state_nxt = S_XX;
      S_XX:   state_nxt = S_YY;
      S_YY:   state_nxt = S_XY;
      S_XY: begin
        if (first_r) begin
          state_nxt = S_UPD;
        end else if (escape_hit || last_iter) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD:  state_nxt = S_XX;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: ready, multiplier operands and ramp control.
  always_comb begin
    in_ready   = 1'b0;
    mul_a      = zx_r;
    mul_b      = zx_r;
    ramp_clear = 1'b0;
    ramp_step  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        ramp_clear = 1'b1;
      end
      S_MX: begin
        mul_a = {22'd0, px_r};
        mul_b = step_x_r;
      end
      S_MY: begin
        mul_a = {22'd0, py_r};
        mul_b = step_y_r;
      end
      S_YY: begin
        mul_a = zy_r;
        mul_b = zy_r;
      end
      S_XY: begin
        mul_a     = zx_r;
        mul_b     = zy_r;
        ramp_step = !first_r && !escape_hit && !last_iter;
      end
      default: ;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    px_nxt    = px_r;
    py_nxt    = py_r;
    zx_nxt    = zx_r;
    zy_nxt    = zy_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    xx_nxt    = xx_r;
    yy_nxt    = yy_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    esc_nxt   = esc_r;
    iter_nxt  = iter_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          px_nxt    = in_pixel_x;
          py_nxt    = in_pixel_y;
          first_nxt = 1'b1;
          cnt_nxt   = '0;
        end
      end
      S_MY: begin
        zx_nxt = sat32(map_x_sum);
        cx_nxt = mode_r[0] ? julia_re_r : sat32(map_x_sum);
      end
      S_MZ: begin
        zy_nxt = sat32(map_y_sum);
        cy_nxt = mode_r[0] ? julia_im_r : sat32(map_y_sum);
      end
      S_YY: xx_nxt = prod_r;
      S_XY: begin
        yy_nxt = prod_r;
        if (!first_r) begin
          if (escape_hit) begin
            esc_nxt  = 1'b1;
            iter_nxt = 9'(cnt_r);
          end else if (last_iter) begin
            esc_nxt  = 1'b0;
            iter_nxt = 9'(ITER_LIMIT);
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      S_UPD: begin
        zx_nxt    = sat32(upd_re_sum);
        zy_nxt    = sat32(upd_im_sum);
        first_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Output register: loaded when the result is done and the slot is free.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_iter_nxt  = out_iter_r;
    out_esc_nxt   = out_esc_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = px_r;
      out_y_nxt     = py_r;
      out_iter_nxt  = iter_r;
      out_esc_nxt   = esc_r;
      if (!esc_r) begin
        out_color_nxt = '0;
      end else if (mode_r[1]) begin
        out_color_nxt = {red_r, green_r, blue_r};
      end else begin
        out_color_nxt = {red_r, 16'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    zx_r        <= zx_nxt;
    zy_r        <= zy_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    xx_r        <= xx_nxt;
    yy_r        <= yy_nxt;
    esc_r       <= esc_nxt;
    iter_r      <= iter_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_iter_r  <= out_iter_nxt;
    out_esc_r   <= out_esc_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_iterations  = out_iter_r;
  assign out_escaped     = out_esc_r;

  // An accepted request always starts with the column mapping multiply.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MX)
    else $error("accepted request did not start mapping");

  // The iteration index never reaches the limit inside the loop.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> cnt_r < CNT_W'(ITER_LIMIT))
    else $error("iteration count beyond limit");

  // A new result only appears from the done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result appeared outside done state");

  // A point that never escaped is black.
  a_black_if_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_esc_r |-> out_color_r == 24'd0)
    else $error("bounded point has nonzero color");

endmodule
